FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ACPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ACPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/acpe_pkg.sv
package acpe_pkg;

  localparam int SCHED_WORDS64_DEF = 30;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int QCW = 3;

  typedef enum logic [2:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_KMODE  = 3'd4,
    CFG_IV_HI  = 3'd5,
    CFG_IV_LO  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {B_IDLE, B_LOAD, B_ROUND, B_EMIT} back_state_t;
  typedef enum logic {KS_IDLE, KS_RUN} ks_state_t;

  typedef struct packed {
    logic         dec;
    logic         final_blk;
    logic         last;
    logic [127:0] blk;
  } entry_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] PAD_FULL   = 8'h10;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] t);
    return {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
  endfunction

  // Clamp the key length mode to what the round key store can hold.
  function automatic logic [1:0] eff_mode(input logic [1:0] mode, input int sw);
    logic [1:0] m;
    m = (mode == 2'd3) ? 2'd2 : mode;
    if (m == 2'd2 && sw < 30) m = 2'd1;
    if (m == 2'd1 && sw < 26) m = 2'd0;
    return m;
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, all;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) b[k] = SBOX[s[127-8*k -: 8]];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[4*c+w] = b[4*((c+w)%4)+w];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0  = t[4*c];
        all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        t[4*c]   = t[4*c]   ^ xtime(t[4*c]   ^ t[4*c+1]) ^ all;
        t[4*c+1] = t[4*c+1] ^ xtime(t[4*c+1] ^ t[4*c+2]) ^ all;
        t[4*c+2] = t[4*c+2] ^ xtime(t[4*c+2] ^ t[4*c+3]) ^ all;
        t[4*c+3] = t[4*c+3] ^ xtime(t[4*c+3] ^ a0) ^ all;
      end
    end
    for (int k = 0; k < 16; k++) r[127-8*k -: 8] = t[k];
    return r ^ rk;
  endfunction

  function automatic logic [7:0] gm9(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ x;
  endfunction
  function automatic logic [7:0] gmb(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(x) ^ x;
  endfunction
  function automatic logic [7:0] gmd(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ x;
  endfunction
  function automatic logic [7:0] gme(input logic [7:0] x);
    return xtime(xtime(xtime(x))) ^ xtime(xtime(x)) ^ xtime(x);
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a, e, f, g;
    logic [127:0] r;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[4*((c+w)%4)+w] = s[127-8*(4*c+w) -: 8];
    for (int k = 0; k < 16; k++) b[k] = INV_SBOX[t[k]] ^ rk[127-8*k -: 8];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a = b[4*c]; e = b[4*c+1]; f = b[4*c+2]; g = b[4*c+3];
        b[4*c]   = gme(a) ^ gmb(e) ^ gmd(f) ^ gm9(g);
        b[4*c+1] = gm9(a) ^ gme(e) ^ gmb(f) ^ gmd(g);
        b[4*c+2] = gmd(a) ^ gm9(e) ^ gme(f) ^ gmb(g);
        b[4*c+3] = gmb(a) ^ gmd(e) ^ gm9(f) ^ gme(g);
      end
    end
    for (int k = 0; k < 16; k++) r[127-8*k -: 8] = b[k];
    return r;
  endfunction

endpackage

FILE: sv/acpe_keysched.sv
module acpe_keysched #(
  parameter int SCHED_WORDS64 = acpe_pkg::SCHED_WORDS64_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [63:0]                           cfg_wdata,
  input  logic [$clog2(SCHED_WORDS64/2)-1:0]    rd_addr,
  output logic [127:0]                          rk_q,
  output logic [3:0]                            rounds,
  output logic                                  busy
);
  import acpe_pkg::*;

  localparam int ROWS = SCHED_WORDS64 / 2;
  localparam int AW   = $clog2(ROWS);
  localparam int IW   = $clog2(2 * SCHED_WORDS64);

  logic [127:0]  mem [ROWS];
  logic [63:0]   key_r [4];
  logic [1:0]    mode_r;
  ks_state_t     st_r, st_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [2:0]    col_r, col_nxt;
  logic [7:0]    rcon_r, rcon_nxt;
  logic [31:0]   win_r [8];
  logic [95:0]   row_r;
  logic [1:0]    m;
  logic [3:0]    nk;
  logic [IW-1:0] total;
  logic [63:0]   kw;
  logic [31:0]   t, w;
  logic          key_wr;

  assign m      = eff_mode(mode_r, SCHED_WORDS64);
  assign nk     = 4'd4 + {1'b0, m, 1'b0};
  assign rounds = 4'd10 + {1'b0, m, 1'b0};
  assign total  = IW'({rounds, 2'b00}) + IW'(4);
  assign busy   = (st_r == KS_RUN);
  assign key_wr = cfg_we && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                  cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3 || cfg_index == CFG_KMODE);

  always_comb begin
    kw = key_r[i_r[2:1]];
    t  = win_r[0];
    if (IW'(nk) > i_r) begin
      w = i_r[0] ? kw[31:0] : kw[63:32];
    end else begin
      if (col_r == 3'd0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rcon_r, 24'h0};
      end else if (nk == 4'd8 && col_r == 3'd4) begin
        t = sub_word(t);
      end
      unique case (m)
        2'd0:    w = win_r[3] ^ t;
        2'd1:    w = win_r[5] ^ t;
        default: w = win_r[7] ^ t;
      endcase
    end
  end

  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    col_nxt  = col_r;
    rcon_nxt = rcon_r;
    if (key_wr) begin
      st_nxt   = KS_RUN;
      i_nxt    = '0;
      col_nxt  = '0;
      rcon_nxt = RCON_FIRST;
    end else if (st_r == KS_RUN) begin
      i_nxt   = i_r + IW'(1);
      col_nxt = (col_r == 3'(nk - 4'd1)) ? 3'd0 : col_r + 3'd1;
      if (IW'(nk) <= i_r && col_r == 3'd0) rcon_nxt = xtime(rcon_r);
      if (i_r == total - IW'(1)) st_nxt = KS_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= KS_RUN;
      i_r    <= '0;
      col_r  <= '0;
      rcon_r <= RCON_FIRST;
      mode_r <= '0;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
    end else begin
      st_r   <= st_nxt;
      i_r    <= i_nxt;
      col_r  <= col_nxt;
      rcon_r <= rcon_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY0:  key_r[0] <= cfg_wdata;
          CFG_KEY1:  key_r[1] <= cfg_wdata;
          CFG_KEY2:  key_r[2] <= cfg_wdata;
          CFG_KEY3:  key_r[3] <= cfg_wdata;
          CFG_KMODE: mode_r   <= cfg_wdata[1:0];
          default:   ;
        endcase
      end
    end
  end

  // Word window and row assembly; the row is written on its fourth word.
  always_ff @(posedge clk) begin
    if (st_r == KS_RUN && !key_wr) begin
      win_r[0] <= w;
      for (int k = 1; k < 8; k++) win_r[k] <= win_r[k-1];
      row_r <= {row_r[63:0], w};
      if (i_r[1:0] == 2'b11) mem[i_r[AW+1:2]] <= {row_r, w};
    end
  end

  always_ff @(posedge clk) begin
    rk_q <= mem[rd_addr];
  end

endmodule

FILE: sv/acpe_front.sv
module acpe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [63:0]           in_block_high,
  input  logic [63:0]           in_block_low,
  input  logic                  in_message_end,
  input  logic [4:0]            in_byte_count,
  input  logic                  key_busy,
  input  logic                  pop,
  output acpe_pkg::entry_t      head,
  output acpe_pkg::front_stat_t stat
);
  import acpe_pkg::*;

  entry_t         q_r [QDEPTH];
  logic [QAW-1:0] rd_r, wr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           acc, pair;
  logic [4:0]     nbytes;
  logic [7:0]     padv;
  entry_t         e0, e1;

  assign in_stall   = key_busy || (cnt_r > QCW'(QDEPTH - 2));
  assign acc        = in_valid && !in_stall;
  assign head       = q_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;

  // Classify: pad a short final encrypt block, queue a full one plus an all-pad block.
  always_comb begin
    nbytes = (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;
    padv   = 8'(5'd16 - nbytes);
    pair   = !in_kind && in_message_end && (nbytes == 5'd16);
    e0.dec       = in_kind;
    e0.final_blk = in_message_end && !pair;
    e0.last      = !pair;
    e0.blk       = {in_block_high, in_block_low};
    if (!in_kind && in_message_end && nbytes != 5'd16) begin
      for (int k = 0; k < 16; k++)
        if (5'(k) >= nbytes) e0.blk[127-8*k -: 8] = padv;
    end
    e1.dec       = 1'b0;
    e1.final_blk = 1'b1;
    e1.last      = 1'b1;
    e1.blk       = {16{PAD_FULL}};
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) cnt_nxt = cnt_nxt + (pair ? QCW'(2) : QCW'(1));
    if (pop) cnt_nxt = cnt_nxt - QCW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_r <= rd_r + QAW'(1);
      if (acc) wr_r <= wr_r + (pair ? QAW'(2) : QAW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_r] <= e0;
      if (pair) q_r[wr_r + QAW'(1)] <= e1;
    end
  end

endmodule

FILE: sv/acpe_back.sv
module acpe_back #(
  parameter int SCHED_WORDS64 = acpe_pkg::SCHED_WORDS64_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [63:0]                        cfg_wdata,
  input  acpe_pkg::entry_t                   head,
  input  acpe_pkg::front_stat_t              fstat,
  input  logic                               key_busy,
  input  logic [3:0]                         rounds,
  input  logic [127:0]                       rk_q,
  output logic [$clog2(SCHED_WORDS64/2)-1:0] rd_addr,
  output acpe_pkg::back_stat_t               bstat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_high,
  output logic [63:0]                        out_low,
  output logic                               out_run_last,
  output logic [4:0]                         out_valid_bytes,
  output logic                               out_status
);
  import acpe_pkg::*;

  localparam int AW = $clog2(SCHED_WORDS64 / 2);

  back_state_t  st_r, st_nxt;
  entry_t       cur_r;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [127:0] s_r, s_nxt;
  logic [127:0] chain_r, chain_nxt, msc_r, msc_nxt, xv_r, xv_nxt;
  logic         inmsg_r, inmsg_nxt;
  logic         ov_r, ov_nxt;
  logic [127:0] res, plain;
  logic [4:0]   vb;
  logic         bad, emit, pop;
  logic [7:0]   pad;
  logic [3:0]   ra;

  assign bstat.idle = (st_r == B_IDLE);
  assign bstat.pop  = pop;
  assign rd_addr    = AW'(ra);
  assign out_valid  = ov_r;

  // Plaintext check on the final decrypt block.
  always_comb begin
    plain = s_r ^ xv_r;
    pad   = plain[7:0];
    bad   = (pad == 8'd0) || (pad > 8'd16);
    for (int k = 0; k < 16; k++)
      if (8'(k) < pad && plain[8*k +: 8] != pad) bad = 1'b1;
  end

  always_comb begin
    st_nxt    = st_r;
    rnd_nxt   = rnd_r;
    s_nxt     = s_r;
    chain_nxt = chain_r;
    msc_nxt   = msc_r;
    xv_nxt    = xv_r;
    inmsg_nxt = inmsg_r;
    ov_nxt    = ov_r && out_stall;
    pop       = 1'b0;
    emit      = 1'b0;
    ra        = rnd_r;
    res       = s_r;
    vb        = 5'd16;
    unique case (st_r)
      B_IDLE: begin
        // Pop the next request and fetch its first round key.
        if (!fstat.empty && !key_busy) begin
          pop    = 1'b1;
          ra     = head.dec ? rounds : 4'd0;
          st_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        if (!inmsg_r) begin
          msc_nxt   = chain_r;
          inmsg_nxt = 1'b1;
        end
        if (cur_r.dec) begin
          xv_nxt    = chain_r;
          chain_nxt = cur_r.blk;
          s_nxt     = cur_r.blk ^ rk_q;
          rnd_nxt   = rounds - 4'd1;
        end else begin
          s_nxt   = cur_r.blk ^ chain_r ^ rk_q;
          rnd_nxt = 4'd1;
        end
        ra     = rnd_nxt;
        st_nxt = B_ROUND;
      end
      B_ROUND: begin
        if (cur_r.dec) begin
          s_nxt = dec_round(s_r, rk_q, rnd_r != 4'd0);
          if (rnd_r == 4'd0) begin
            st_nxt = B_EMIT;
          end else begin
            rnd_nxt = rnd_r - 4'd1;
            ra      = rnd_nxt;
          end
        end else begin
          s_nxt = enc_round(s_r, rk_q, rnd_r == rounds);
          if (rnd_r == rounds) begin
            st_nxt = B_EMIT;
          end else begin
            rnd_nxt = rnd_r + 4'd1;
            ra      = rnd_nxt;
          end
        end
      end
      B_EMIT: begin
        if (cur_r.dec) begin
          res = plain;
          if (cur_r.final_blk && bad) begin
            res       = '0;
            vb        = 5'd0;
            chain_nxt = msc_r;
          end else if (cur_r.final_blk) begin
            vb = 5'd16 - pad[4:0];
          end
        end else begin
          chain_nxt = s_r;
        end
        if (!ov_r || !out_stall) begin
          emit   = 1'b1;
          ov_nxt = 1'b1;
          if (cur_r.final_blk) inmsg_nxt = 1'b0;
          st_nxt = B_IDLE;
        end else begin
          chain_nxt = chain_r;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
    // IV writes reload the chain and open a new message.
    if (cfg_we && cfg_index == CFG_IV_HI) begin
      chain_nxt[127:64] = cfg_wdata;
      inmsg_nxt         = 1'b0;
    end
    if (cfg_we && cfg_index == CFG_IV_LO) begin
      chain_nxt[63:0] = cfg_wdata;
      inmsg_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      ov_r    <= 1'b0;
      inmsg_r <= 1'b0;
      chain_r <= '0;
      msc_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      ov_r    <= ov_nxt;
      inmsg_r <= inmsg_nxt;
      chain_r <= chain_nxt;
      msc_r   <= msc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    s_r   <= s_nxt;
    xv_r  <= xv_nxt;
    if (pop) cur_r <= head;
    if (emit) begin
      out_high        <= res[127:64];
      out_low         <= res[63:0];
      out_run_last    <= cur_r.last;
      out_valid_bytes <= vb;
      out_status      <= cur_r.dec && cur_r.final_blk && bad;
    end
  end

endmodule

FILE: sv/aes_cbc_pkcs7_engine.sv
// AES-128/192/256 CBC engine with PKCS#7 padding.
// Input channel (in_valid/in_stall): one 16-byte block per request with a
// direction (in_kind), a message-end mark and a byte count for the final
// encrypt block. Output channel (out_valid/out_stall): one result block per
// request, two for a full final encrypt block (the second is all pad bytes).
// cfg_we/cfg_index/cfg_wdata write keys, key length mode and IV halves; write
// only while the engine is idle. A key or mode write re-expands the round keys,
// one 32-bit word per cycle, and input is held off meanwhile.
// Reset runs the same expansion for the all-zero 128-bit key.
// In the back end a block passes through pop, whitening, the AES rounds one
// by one, and emit; blocks run one at a time because CBC chains each block
// to the previous one. The back end has an iterated round unit and a single
// round key memory port.
// A four-entry request queue sits between the classifier and the cipher, so
// input keeps flowing while at most two entries are queued and the result
// register waits on out_stall; the cipher holds its block while the receiver stalls.
module aes_cbc_pkcs7_engine #(
  parameter int SCHED_WORDS64 = acpe_pkg::SCHED_WORDS64_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_message_end,
  input  logic [4:0]  in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic        out_run_last,
  output logic [4:0]  out_valid_bytes,
  output logic        out_status
);
  import acpe_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = $clog2(SCHED_WORDS64 / 2);

  entry_t        head;
  front_stat_t   fstat;
  back_stat_t    bstat;
  logic          key_busy;
  logic [3:0]    rounds;
  logic [127:0]  rk_q;
  logic [AW-1:0] rd_addr;

  // Round key expansion and storage.
  acpe_keysched #(.SCHED_WORDS64(SCHED_WORDS64)) u_ks (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .rd_addr, .rk_q, .rounds, .busy(key_busy)
  );

  // Accept and classify requests, queue them.
  acpe_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_block_high, .in_block_low,
    .in_message_end, .in_byte_count, .key_busy, .pop(bstat.pop), .head, .stat(fstat)
  );

  // Run the cipher, chain and check padding.
  acpe_back #(.SCHED_WORDS64(SCHED_WORDS64)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .head, .fstat, .key_busy,
    .rounds, .rk_q, .rd_addr, .bstat, .out_valid, .out_stall, .out_high, .out_low,
    .out_run_last, .out_valid_bytes, .out_status
  );

  // Cipher must sit idle while round keys are rebuilt.
  `ACPE_ASSERT_IMP(a_idle_in_expand, key_busy, bstat.idle)
  // An accepted request lands in the queue.
  `ACPE_ASSERT_NXT(a_accept_queued, in_valid && !in_stall, !fstat.empty)
  // Never pop an empty queue.
  `ACPE_ASSERT_IMP(a_pop_nonempty, bstat.pop, !fstat.empty)
  // Only the first half of a padded pair is not last, and it is never an error.
  `ACPE_ASSERT_IMP(a_pair_ok, out_valid && !out_run_last, !out_status)

endmodule
